// ===== rtl/core/lnvs_pkg.sv =====
// Package with the state type and fixed constants of the lane nearest vehicle selector.
`timescale 1ns / 1ps
`default_nettype none

package lnvs_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_MTIME,
        ST_DLO,
        ST_DHI,
        ST_JUDGE,
        ST_EMIT
    } state_t;

    localparam int unsigned NSLOT = 5;

    localparam logic [2:0] SLOT_OWN_AHEAD    = 3'd0;
    localparam logic [2:0] SLOT_LEFT_AHEAD   = 3'd1;
    localparam logic [2:0] SLOT_LEFT_BEHIND  = 3'd2;
    localparam logic [2:0] SLOT_RIGHT_AHEAD  = 3'd3;
    localparam logic [2:0] SLOT_RIGHT_BEHIND = 3'd4;

    localparam logic [1:0] CFG_EGO_LANE      = 2'd0;
    localparam logic [1:0] CFG_EGO_FUTURE_S  = 2'd1;
    localparam logic [1:0] CFG_HORIZON_TICKS = 2'd2;

    localparam logic [1:0]  LANE_RIGHTMOST = 2'd2;
    localparam logic [15:0] GAP_LIMIT      = 16'd64000;

    // ceil(2^28 / 25) split into 12-bit halves; divides by 25 after a shift by 3
    localparam logic [15:0] RECIP_HI = 16'h0A3D;
    localparam logic [15:0] RECIP_LO = 16'h070B;

    localparam logic [3:0] SQRT_STEPS_M1 = 4'd15;

endpackage

`default_nettype wire

// ===== rtl/core/lane_nearest_vehicle_selector.sv =====
// Top level: per-lane nearest vehicle selector with a shared multiplier and iterative square root.
// Each car passes the squares, the square root, the time product and the divide, then ST_JUDGE.
// Busy stays high meanwhile, so a new car is taken only in ST_IDLE; a car carrying last_car first
// emits all five slot results. The 16-step square root loop and five multiplier passes do the work.
// Results come one per cycle with result_valid; the receiver cannot stall them.
// Reset clears all slots and loads ego_lane 1, ego_future_s 0, horizon_ticks 50.
`timescale 1ns / 1ps
`default_nettype none

module lane_nearest_vehicle_selector (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [9:0]         lateral_d,
    input  wire logic [19:0]        position_s,
    input  wire logic signed [15:0] vel_x,
    input  wire logic signed [15:0] vel_y,
    input  wire logic               last_car,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [20:0]        cfg_data,
    output logic                    result_valid,
    output logic [2:0]              slot,
    output logic                    found,
    output logic [15:0]             gap,
    output logic [15:0]             speed,
    output logic                    last_slot
);

    lnvs_pkg::state_t state_reg, state_next;

    logic [1:0]  ego_lane_reg;
    logic [20:0] ego_future_s_reg;
    logic [9:0]  horizon_ticks_reg;

    logic [3:0]  cnt_reg, cnt_next;
    logic [2:0]  slot_idx_reg, slot_idx_next;
    logic [4:0]  slot_found_reg, slot_found_next;

    logic [47:0] acc_reg, acc_next;
    logic [31:0] root_reg, root_next;
    logic [22:0] y_reg, y_next;
    logic [9:0]  d_reg, d_next;
    logic [19:0] s_reg, s_next;
    logic [15:0] ax_reg, ax_next;
    logic [15:0] ay_reg, ay_next;
    logic        last_reg, last_next;
    logic [15:0] best_gap_reg [lnvs_pkg::NSLOT];
    logic [15:0] best_gap_next [lnvs_pkg::NSLOT];
    logic [15:0] best_speed_reg [lnvs_pkg::NSLOT];
    logic [15:0] best_speed_next [lnvs_pkg::NSLOT];

    logic [23:0] mul_a;
    logic [15:0] mul_b;
    logic [39:0] mul_p;

    logic [31:0] sq_bit;
    logic [31:0] sq_trial;
    logic [20:0] fut;
    logic [20:0] gap_ahead;
    logic [20:0] gap_behind;
    logic        is_ahead;
    logic        is_behind;
    logic        in_own;
    logic        in_left;
    logic        in_right;
    logic [1:0]  left_lane;
    logic [1:0]  right_lane;
    logic        tgt_valid;
    logic [2:0]  tgt_slot;
    logic [20:0] tgt_gap;
    logic [15:0] cur_best;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != lnvs_pkg::ST_IDLE);

    assign mul_p    = mul_a * mul_b;
    assign sq_bit   = 32'd1 << {cnt_reg, 1'b0};
    assign sq_trial = root_reg + sq_bit;

    assign fut        = {1'b0, s_reg} + {1'b0, acc_reg[47:28]};
    assign is_ahead   = fut > ego_future_s_reg;
    assign is_behind  = fut < ego_future_s_reg;
    assign gap_ahead  = fut - ego_future_s_reg;
    assign gap_behind = ego_future_s_reg - fut;
    assign left_lane  = ego_lane_reg - 2'd1;
    assign right_lane = ego_lane_reg + 2'd1;
    assign in_own     = (d_reg[9:8] == ego_lane_reg) && (d_reg[7:0] != 8'd0);
    assign in_left    = (ego_lane_reg != 2'd0) && (d_reg[9:8] == left_lane)
                        && (d_reg[7:0] != 8'd0);
    assign in_right   = (ego_lane_reg < lnvs_pkg::LANE_RIGHTMOST)
                        && (d_reg[9:8] == right_lane) && (d_reg[7:0] != 8'd0);

    always_comb
    begin
        tgt_valid = 1'b1;
        tgt_slot  = lnvs_pkg::SLOT_OWN_AHEAD;
        tgt_gap   = gap_ahead;
        priority if (in_own && is_ahead)
        begin
            tgt_slot = lnvs_pkg::SLOT_OWN_AHEAD;
        end
        else if (in_left && is_ahead)
        begin
            tgt_slot = lnvs_pkg::SLOT_LEFT_AHEAD;
        end
        else if (in_left && is_behind)
        begin
            tgt_slot = lnvs_pkg::SLOT_LEFT_BEHIND;
            tgt_gap  = gap_behind;
        end
        else if (in_right && is_ahead)
        begin
            tgt_slot = lnvs_pkg::SLOT_RIGHT_AHEAD;
        end
        else if (in_right && is_behind)
        begin
            tgt_slot = lnvs_pkg::SLOT_RIGHT_BEHIND;
            tgt_gap  = gap_behind;
        end
        else
        begin
            tgt_valid = 1'b0;
        end
    end

    assign cur_best = slot_found_reg[tgt_slot] ? best_gap_reg[tgt_slot] : lnvs_pkg::GAP_LIMIT;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        slot_idx_next   = slot_idx_reg;
        slot_found_next = slot_found_reg;
        acc_next        = acc_reg;
        root_next       = root_reg;
        y_next          = y_reg;
        d_next          = d_reg;
        s_next          = s_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        last_next       = last_reg;
        best_gap_next   = best_gap_reg;
        best_speed_next = best_speed_reg;
        mul_a           = {8'd0, ax_reg};
        mul_b           = ax_reg;
        result_valid    = 1'b0;
        slot            = slot_idx_reg;
        found           = 1'b0;
        gap             = 16'd0;
        speed           = 16'd0;
        last_slot       = 1'b0;

        unique case (state_reg)
            lnvs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    d_next     = lateral_d;
                    s_next     = position_s;
                    ax_next    = vel_x[15] ? 16'(-vel_x) : vel_x;
                    ay_next    = vel_y[15] ? 16'(-vel_y) : vel_y;
                    last_next  = last_car;
                    state_next = lnvs_pkg::ST_SQX;
                end
            end
            lnvs_pkg::ST_SQX:
            begin
                acc_next   = {8'd0, mul_p};
                state_next = lnvs_pkg::ST_SQY;
            end
            lnvs_pkg::ST_SQY:
            begin
                mul_a      = {8'd0, ay_reg};
                mul_b      = ay_reg;
                acc_next   = acc_reg + {8'd0, mul_p};
                root_next  = 32'd0;
                cnt_next   = lnvs_pkg::SQRT_STEPS_M1;
                state_next = lnvs_pkg::ST_SQRT;
            end
            lnvs_pkg::ST_SQRT:
            begin
                if (acc_reg[31:0] >= sq_trial)
                begin
                    acc_next  = {16'd0, acc_reg[31:0] - sq_trial};
                    root_next = (root_reg >> 1) + sq_bit;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                if (cnt_reg == 4'd0)
                begin
                    state_next = lnvs_pkg::ST_MTIME;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            lnvs_pkg::ST_MTIME:
            begin
                mul_a      = {8'd0, root_reg[15:0]};
                mul_b      = {6'd0, horizon_ticks_reg};
                y_next     = mul_p[25:3];
                state_next = lnvs_pkg::ST_DLO;
            end
            lnvs_pkg::ST_DLO:
            begin
                mul_a      = {1'b0, y_reg};
                mul_b      = lnvs_pkg::RECIP_LO;
                acc_next   = {8'd0, mul_p};
                state_next = lnvs_pkg::ST_DHI;
            end
            lnvs_pkg::ST_DHI:
            begin
                mul_a      = {1'b0, y_reg};
                mul_b      = lnvs_pkg::RECIP_HI;
                acc_next   = acc_reg + {mul_p[35:0], 12'd0};
                state_next = lnvs_pkg::ST_JUDGE;
            end
            lnvs_pkg::ST_JUDGE:
            begin
                if (tgt_valid && (tgt_gap < {5'd0, cur_best}))
                begin
                    best_gap_next[tgt_slot]   = tgt_gap[15:0];
                    best_speed_next[tgt_slot] = root_reg[15:0];
                    slot_found_next[tgt_slot] = 1'b1;
                end
                slot_idx_next = lnvs_pkg::SLOT_OWN_AHEAD;
                state_next    = last_reg ? lnvs_pkg::ST_EMIT : lnvs_pkg::ST_IDLE;
            end
            lnvs_pkg::ST_EMIT:
            begin
                result_valid = 1'b1;
                found        = slot_found_reg[slot_idx_reg];
                gap          = found ? best_gap_reg[slot_idx_reg] : 16'd0;
                speed        = found ? best_speed_reg[slot_idx_reg] : 16'd0;
                last_slot    = (slot_idx_reg == lnvs_pkg::SLOT_RIGHT_BEHIND);
                if (last_slot)
                begin
                    slot_found_next = 5'd0;
                    state_next      = lnvs_pkg::ST_IDLE;
                end
                else
                begin
                    slot_idx_next = slot_idx_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = lnvs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lnvs_pkg::ST_IDLE;
            cnt_reg        <= 4'd0;
            slot_idx_reg   <= 3'd0;
            slot_found_reg <= 5'd0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            slot_idx_reg   <= slot_idx_next;
            slot_found_reg <= slot_found_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ego_lane_reg      <= 2'd1;
            ego_future_s_reg  <= 21'd0;
            horizon_ticks_reg <= 10'd50;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lnvs_pkg::CFG_EGO_LANE:      ego_lane_reg      <= cfg_data[1:0];
                lnvs_pkg::CFG_EGO_FUTURE_S:  ego_future_s_reg  <= cfg_data;
                lnvs_pkg::CFG_HORIZON_TICKS: horizon_ticks_reg <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        root_reg       <= root_next;
        y_reg          <= y_next;
        d_reg          <= d_next;
        s_reg          <= s_next;
        ax_reg         <= ax_next;
        ay_reg         <= ay_next;
        last_reg       <= last_next;
        best_gap_reg   <= best_gap_next;
        best_speed_reg <= best_speed_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe outside a busy period");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_slot |=> result_valid && (slot == $past(slot) + 3'd1))
        else $error("result sequence broken");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_slot |=> !busy && (slot_found_reg == 5'd0))
        else $error("slots not cleared after frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && found |-> (gap != 16'd0) && (gap < lnvs_pkg::GAP_LIMIT))
        else $error("found slot with gap out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !result_valid)
        else $error("transfer not followed by busy");

endmodule

`default_nettype wire
